FILE: design/coffrel_pkg.sv
`default_nettype none

package coffrel_pkg;

  // field widths of the relocation interface
  localparam int unsigned KindW   = 3;
  localparam int unsigned AddrW   = 64;
  localparam int unsigned OffW    = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 4;

  // bytes written per relocation width
  localparam logic [CountW-1:0] WideBytes   = 4'd8;
  localparam logic [CountW-1:0] NarrowBytes = 4'd4;
  localparam logic [CountW-1:0] NoBytes     = 4'd0;

  // relocation kinds
  typedef enum logic [KindW-1:0] {
    KIND_ADDR64   = 3'd0,
    KIND_ADDR32NB = 3'd1,
    KIND_REL32    = 3'd2,
    KIND_SECREL   = 3'd3
  } kind_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_KIND = 3'd1,
    ST_PAST_END = 3'd2,
    ST_REL32    = 3'd3,
    ST_ADDR64   = 3'd4,
    ST_ADDR32NB = 3'd5,
    ST_SECREL   = 3'd6
  } status_e;

  // one relocation request
  typedef struct packed {
    logic [KindW-1:0] command;
    logic [AddrW-1:0] target_address;
    logic [OffW-1:0]  target_section_offset;
    logic [AddrW-1:0] section_address;
    logic [OffW-1:0]  site_offset;
    logic [OffW-1:0]  section_size;
    logic [AddrW-1:0] stored_bytes;
  } request_t;

  // one relocation result
  typedef struct packed {
    status_e           status;
    logic [AddrW-1:0]  patched_bytes;
    logic [CountW-1:0] byte_count;
  } result_t;

endpackage

`default_nettype wire

FILE: design/coffrel_calc.sv
`default_nettype none

module coffrel_calc (
  input  coffrel_pkg::request_t        req_i,
  input  logic [coffrel_pkg::AddrW-1:0] load_base_i,
  output coffrel_pkg::result_t         res_o
);
  import coffrel_pkg::*;

  logic [AddrW-1:0]  addend;
  logic [AddrW-1:0]  rel32_val;
  logic [AddrW-1:0]  addr64_val;
  logic [AddrW-1:0]  nb_base;
  logic [AddrW-1:0]  nb_val;
  logic [AddrW-1:0]  secrel_val;
  logic [OffW:0]     patch_end;
  logic [CountW-1:0] width;
  logic              kind_ok;
  logic              past_end;

  // kind decode and patch width
  always_comb begin
    kind_ok = 1'b1;
    width   = NarrowBytes;
    unique case (req_i.command) inside
      KIND_ADDR64:   width = WideBytes;
      KIND_ADDR32NB,
      KIND_REL32,
      KIND_SECREL:   width = NarrowBytes;
      default:       kind_ok = 1'b0;
    endcase
  end

  // section bound, 33-bit so no wrap
  assign patch_end = {1'b0, req_i.site_offset} + {{(OffW+1-CountW){1'b0}}, width};
  assign past_end  = patch_end > {1'b0, req_i.section_size};

  // addend from stored bytes, sign-extended for 4-byte kinds
  assign addend = (req_i.command == KIND_ADDR64) ? req_i.stored_bytes :
                  {{(AddrW-OffW){req_i.stored_bytes[OffW-1]}}, req_i.stored_bytes[OffW-1:0]};

  // candidate values, all modulo 2^64
  assign rel32_val  = req_i.target_address + addend - req_i.section_address
                      - {{(AddrW-OffW){1'b0}}, req_i.site_offset} - AddrW'(4);
  assign addr64_val = req_i.target_address + addend;
  assign nb_base    = ((load_base_i != '0) && (req_i.target_address >= load_base_i)) ?
                      (req_i.target_address - load_base_i) : req_i.target_address;
  assign nb_val     = nb_base + addend;
  assign secrel_val = {{(AddrW-OffW){1'b0}}, req_i.target_section_offset} + addend;

  // select result and range checks
  always_comb begin
    res_o.status        = ST_OK;
    res_o.patched_bytes = '0;
    res_o.byte_count    = NoBytes;
    if (!kind_ok) begin
      res_o.status = ST_BAD_KIND;
    end else if (past_end) begin
      res_o.status = ST_PAST_END;
    end else begin
      unique case (req_i.command)
        KIND_REL32: begin
          if ((rel32_val[AddrW-1:OffW-1] != '0) && (rel32_val[AddrW-1:OffW-1] != '1)) begin
            res_o.status = ST_REL32;
          end else begin
            res_o.patched_bytes = {{(AddrW-OffW){1'b0}}, rel32_val[OffW-1:0]};
            res_o.byte_count    = NarrowBytes;
          end
        end
        KIND_ADDR64: begin
          if (addr64_val[AddrW-1]) begin
            res_o.status = ST_ADDR64;
          end else begin
            res_o.patched_bytes = addr64_val;
            res_o.byte_count    = WideBytes;
          end
        end
        KIND_ADDR32NB: begin
          if (nb_val[AddrW-1:OffW] != '0) begin
            res_o.status = ST_ADDR32NB;
          end else begin
            res_o.patched_bytes = nb_val;
            res_o.byte_count    = NarrowBytes;
          end
        end
        default: begin
          if (secrel_val[AddrW-1:OffW] != '0) begin
            res_o.status = ST_SECREL;
          end else begin
            res_o.patched_bytes = secrel_val;
            res_o.byte_count    = NarrowBytes;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/coff_amd64_relocation_patch.sv
`default_nettype none

// channel      direction  handshake               payload
// -----------  ---------  ----------------------  ---------------------------------------
// input        in         in_valid_i/in_stall_o   command .. stored_bytes
// result       out        out_valid_o/out_stall_i status, patched_bytes, byte_count
// load_base    in         load_base_we_i          load_base_i (write only)
//
// two register stages: request register, then result register; the relocation math sits
// between the two registers. one transaction per cycle sustained while out_stall_i is low.
// asynchronous active-low reset clears the valid flags and the load base register.
// a stall on the result side holds the result register and backs up into the request
// register; in_stall_o rises only when the request register is full and cannot move on.

module coff_amd64_relocation_patch (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              load_base_we_i,
  input  logic [coffrel_pkg::AddrW-1:0]     load_base_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [coffrel_pkg::KindW-1:0]     command_i,
  input  logic [coffrel_pkg::AddrW-1:0]     target_address_i,
  input  logic [coffrel_pkg::OffW-1:0]      target_section_offset_i,
  input  logic [coffrel_pkg::AddrW-1:0]     section_address_i,
  input  logic [coffrel_pkg::OffW-1:0]      site_offset_i,
  input  logic [coffrel_pkg::OffW-1:0]      section_size_i,
  input  logic [coffrel_pkg::AddrW-1:0]     stored_bytes_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [coffrel_pkg::StatusW-1:0]   status_o,
  output logic [coffrel_pkg::AddrW-1:0]     patched_bytes_o,
  output logic [coffrel_pkg::CountW-1:0]    byte_count_o
);
  import coffrel_pkg::*;

  logic [AddrW-1:0] load_base_q;
  request_t         req_q;
  logic             req_valid_q;
  result_t          res_d;
  result_t          res_q;
  logic             res_valid_q;
  logic             res_load;
  logic             req_load;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_base_q <= '0;
    end else if (load_base_we_i) begin
      load_base_q <= load_base_i;
    end
  end

  // pipeline flow control
  assign res_load   = !res_valid_q || !out_stall_i;
  assign in_stall_o = req_valid_q && !res_load;
  assign req_load   = in_valid_i && !in_stall_o;

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_load) begin
      req_q <= '{command:               command_i,
                 target_address:        target_address_i,
                 target_section_offset: target_section_offset_i,
                 section_address:       section_address_i,
                 site_offset:           site_offset_i,
                 section_size:          section_size_i,
                 stored_bytes:          stored_bytes_i};
    end
  end

  // relocation math
  coffrel_calc u_calc (
    .req_i       (req_q),
    .load_base_i (load_base_q),
    .res_o       (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load && req_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = res_valid_q;
  assign status_o        = res_q.status;
  assign patched_bytes_o = res_q.patched_bytes;
  assign byte_count_o    = res_q.byte_count;

  // checks
  a_err_no_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (res_q.status != ST_OK)) |-> ((byte_count_o == NoBytes) &&
                                                 (patched_bytes_o == '0)))
    else $error("error result carries bytes");

  a_ok_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (res_q.status == ST_OK)) |-> ((byte_count_o == WideBytes) ||
                                                 (byte_count_o == NarrowBytes)))
    else $error("ok result with bad byte count");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (req_valid_q && res_valid_q && out_stall_i))
    else $error("input stalled while pipeline can move");

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(res_q)))
    else $error("stalled result lost or changed");

endmodule

`default_nettype wire
